>>> hdl/event_stream_framer_core_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the event stream framer core.
// ---------------------------------------------------------------------------
`ifndef EVENT_STREAM_FRAMER_CORE_DEFINES_SVH
`define EVENT_STREAM_FRAMER_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ESF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define ESF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed in the next cycle");

`endif

>>> hdl/esf_pkg.sv
// ---------------------------------------------------------------------------
// esf_pkg
// Types and constants shared by the event stream framer modules.
// ---------------------------------------------------------------------------
package esf_pkg;

    // Framing formats selected by the frame_format register.
    localparam logic [1:0] FMT_MARK  = 2'd0;
    localparam logic [1:0] FMT_FLAGS = 2'd1;
    localparam logic [1:0] FMT_STRIP = 2'd2;
    localparam logic [1:0] FMT_SPARE = 2'd3;

    // Register indexes on the configuration port.
    localparam logic [1:0] CFG_FRAME_FORMAT    = 2'd0;
    localparam logic [1:0] CFG_MAX_EVENT_WORDS = 2'd1;

    localparam logic [1:0]  FRAME_FORMAT_RESET    = FMT_MARK;
    localparam logic [15:0] MAX_EVENT_WORDS_RESET = 16'd40000;

    // Top three bits of a word used as markers.
    localparam logic [2:0] TOP_HDR_101 = 3'b101;
    localparam logic [2:0] TOP_TRL_110 = 3'b110;
    localparam logic [2:0] TOP_TRL_111 = 3'b111;

    localparam int BIT_START = 15;
    localparam int BIT_END   = 14;

    // Result buffer depth; must be a power of two and at least four.
    localparam int RES_DEPTH = 4;
    localparam int RES_PTR_W = $clog2(RES_DEPTH);

    typedef struct packed {
        logic [15:0] event_word;
        logic        word_present;
        logic        last;
        logic        start_error;
        logic        end_error;
        logic        overflow;
    } esf_result_t;

    // Results produced by one accepted input word.
    typedef struct packed {
        logic [1:0]  count;
        esf_result_t first;
        esf_result_t second;
    } esf_push_t;

endpackage

>>> hdl/event_stream_framer_core.sv
// ---------------------------------------------------------------------------
// event_stream_framer_core
// Splits a stream of 16-bit readout words into events using marker bits.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready   | sample_word
//  out     | output    | out_valid / out_ready | event_word, word_present, last,
//          |           |                       | start_error, end_error, overflow
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// One input word is accepted per cycle while in_ready is high; its results
// go to a four-entry result queue in the same cycle and are offered one per
// cycle from the next while out_ready is high. In the flag and mark formats,
// a word closing one event and opening another gives two; input continues.
// in_ready drops only while the queue lacks room for two results.
// Reset clears the framing state and the queue; configuration is always taken.
module event_stream_framer_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] sample_word,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] event_word,
    output logic        word_present,
    output logic        last,
    output logic        start_error,
    output logic        end_error,
    output logic        overflow,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);
    import esf_pkg::*;

    logic [1:0]  frame_format_reg;
    logic [15:0] max_event_words_reg;
    logic        in_accept;
    logic        out_pop;
    logic        room;
    esf_push_t   push;
    esf_result_t head;

    assign cfg_ready = 1'b1;
    assign in_accept = in_valid && in_ready;
    assign out_pop   = out_valid && out_ready;
    assign in_ready  = room;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_format_reg    <= FRAME_FORMAT_RESET;
            max_event_words_reg <= MAX_EVENT_WORDS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_FRAME_FORMAT:    frame_format_reg    <= cfg_data[1:0];
                CFG_MAX_EVENT_WORDS: max_event_words_reg <= cfg_data;
                default:             ;
            endcase
        end
    end

    esf_framer u_framer (
        .clk             (clk),
        .rst_n           (rst_n),
        .accept          (in_accept),
        .sample_word     (sample_word),
        .frame_format    (frame_format_reg),
        .max_event_words (max_event_words_reg),
        .push            (push)
    );

    esf_result_buffer u_results (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .pop       (out_pop),
        .room      (room),
        .not_empty (out_valid),
        .head      (head)
    );

    assign event_word   = head.event_word;
    assign word_present = head.word_present;
    assign last         = head.last;
    assign start_error  = head.start_error;
    assign end_error    = head.end_error;
    assign overflow     = head.overflow;

endmodule

>>> hdl/esf_framer.sv
// ---------------------------------------------------------------------------
// esf_framer
// Framing state and per-word decision; produces up to two results per word.
// ---------------------------------------------------------------------------
module esf_framer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               accept,
    input  logic [15:0]        sample_word,
    input  logic [1:0]         frame_format,
    input  logic [15:0]        max_event_words,
    output esf_pkg::esf_push_t push
);
    import esf_pkg::*;

    logic        in_event_reg, in_event_next;
    logic        skip_reg, skip_next;
    logic [15:0] count_reg, count_next;
    logic        pend_reg, pend_next;
    logic        ovf_reg, ovf_next;

    logic [2:0]  top3;

    function automatic esf_result_t make_result(
        input logic [15:0] word,
        input logic        present,
        input logic        last,
        input logic        serr,
        input logic        eerr,
        input logic        ovf
    );
        esf_result_t r;
        r.event_word   = present ? word : 16'd0;
        r.word_present = present;
        r.last         = last;
        r.start_error  = serr;
        r.end_error    = eerr;
        r.overflow     = ovf;
        return r;
    endfunction

    assign top3 = sample_word[15:13];

    always_comb
    begin
        in_event_next = in_event_reg;
        skip_next     = skip_reg;
        count_next    = count_reg;
        pend_next     = pend_reg;
        ovf_next      = ovf_reg;
        push          = '0;

        if (accept)
        begin
            if (skip_reg)
            begin
                skip_next = 1'b0;
            end
            else
            begin
                unique case (frame_format) inside
                    FMT_FLAGS:
                    begin
                        if (!in_event_reg)
                        begin
                            if (sample_word[BIT_START])
                            begin
                                push.count = 2'd1;
                                if (sample_word[BIT_END])
                                begin
                                    // Both flags while searching: a one-word event.
                                    push.first = make_result(sample_word, 1'b1, 1'b1,
                                                             pend_reg, 1'b0, ovf_reg);
                                    skip_next  = 1'b0;
                                    count_next = 16'd0;
                                    pend_next  = 1'b0;
                                    ovf_next   = 1'b0;
                                end
                                else
                                begin
                                    push.first = make_result(sample_word, 1'b1, 1'b0,
                                                             pend_reg, 1'b0, 1'b0);
                                    in_event_next = 1'b1;
                                    count_next    = 16'd1;
                                    ovf_next      = 1'b0;
                                end
                            end
                            else
                            begin
                                pend_next = 1'b1;
                            end
                        end
                        else if (sample_word[BIT_END])
                        begin
                            push.count    = 2'd1;
                            push.first    = make_result(sample_word, 1'b1, 1'b1,
                                                        pend_reg, 1'b0, ovf_reg);
                            in_event_next = 1'b0;
                            skip_next     = 1'b0;
                            count_next    = 16'd0;
                            pend_next     = 1'b0;
                            ovf_next      = 1'b0;
                        end
                        else if (sample_word[BIT_START])
                        begin
                            push.count    = 2'd2;
                            push.first    = make_result(16'd0, 1'b0, 1'b1,
                                                        pend_reg, 1'b1, ovf_reg);
                            push.second   = make_result(sample_word, 1'b1, 1'b0,
                                                        1'b0, 1'b0, 1'b0);
                            in_event_next = 1'b1;
                            skip_next     = 1'b0;
                            count_next    = 16'd1;
                            pend_next     = 1'b0;
                            ovf_next      = 1'b0;
                        end
                        else if (count_reg >= max_event_words)
                        begin
                            // Oversize event closes at once; the next one starts in error.
                            push.count    = 2'd1;
                            push.first    = make_result(16'd0, 1'b0, 1'b1,
                                                        pend_reg, 1'b1, 1'b1);
                            in_event_next = 1'b0;
                            skip_next     = 1'b0;
                            count_next    = 16'd0;
                            pend_next     = 1'b1;
                            ovf_next      = 1'b0;
                        end
                        else
                        begin
                            push.count = 2'd1;
                            push.first = make_result(sample_word, 1'b1, 1'b0,
                                                     pend_reg, 1'b0, ovf_reg);
                            count_next = count_reg + 16'd1;
                        end
                    end

                    FMT_STRIP:
                    begin
                        if (!in_event_reg)
                        begin
                            if (top3 == TOP_HDR_101)
                            begin
                                in_event_next = 1'b1;
                                count_next    = 16'd0;
                                ovf_next      = 1'b0;
                                skip_next     = 1'b1;
                            end
                            else
                            begin
                                pend_next = 1'b1;
                            end
                        end
                        else if (top3 == TOP_TRL_111)
                        begin
                            push.count    = 2'd1;
                            push.first    = make_result(16'd0, 1'b0, 1'b1,
                                                        pend_reg, 1'b0, ovf_reg);
                            in_event_next = 1'b0;
                            skip_next     = 1'b0;
                            count_next    = 16'd0;
                            pend_next     = 1'b0;
                            ovf_next      = 1'b0;
                        end
                        else if (top3 == TOP_HDR_101)
                        begin
                            push.count    = 2'd1;
                            push.first    = make_result(16'd0, 1'b0, 1'b1,
                                                        pend_reg, 1'b1, ovf_reg);
                            in_event_next = 1'b1;
                            skip_next     = 1'b1;
                            count_next    = 16'd0;
                            pend_next     = 1'b0;
                            ovf_next      = 1'b0;
                        end
                        else if (count_reg < max_event_words)
                        begin
                            push.count = 2'd1;
                            push.first = make_result(sample_word, 1'b1, 1'b0,
                                                     pend_reg, 1'b0, ovf_reg);
                            count_next = count_reg + 16'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end

                    FMT_MARK, FMT_SPARE:
                    begin
                        if (!in_event_reg)
                        begin
                            if (top3 == TOP_HDR_101)
                            begin
                                push.count    = 2'd1;
                                push.first    = make_result(sample_word, 1'b1, 1'b0,
                                                            pend_reg, 1'b0, 1'b0);
                                in_event_next = 1'b1;
                                count_next    = 16'd1;
                                ovf_next      = 1'b0;
                            end
                            else
                            begin
                                pend_next = 1'b1;
                            end
                        end
                        else if (top3 == TOP_TRL_110)
                        begin
                            push.count    = 2'd1;
                            push.first    = make_result(sample_word, 1'b1, 1'b1,
                                                        pend_reg, 1'b0, ovf_reg);
                            in_event_next = 1'b0;
                            skip_next     = 1'b0;
                            count_next    = 16'd0;
                            pend_next     = 1'b0;
                            ovf_next      = 1'b0;
                        end
                        else if (top3 == TOP_HDR_101)
                        begin
                            push.count    = 2'd2;
                            push.first    = make_result(16'd0, 1'b0, 1'b1,
                                                        pend_reg, 1'b1, ovf_reg);
                            push.second   = make_result(sample_word, 1'b1, 1'b0,
                                                        1'b0, 1'b0, 1'b0);
                            in_event_next = 1'b1;
                            skip_next     = 1'b0;
                            count_next    = 16'd1;
                            pend_next     = 1'b0;
                            ovf_next      = 1'b0;
                        end
                        else if (count_reg < max_event_words)
                        begin
                            push.count = 2'd1;
                            push.first = make_result(sample_word, 1'b1, 1'b0,
                                                     pend_reg, 1'b0, ovf_reg);
                            count_next = count_reg + 16'd1;
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_event_reg <= 1'b0;
            skip_reg     <= 1'b0;
            count_reg    <= 16'd0;
            pend_reg     <= 1'b0;
            ovf_reg      <= 1'b0;
        end
        else
        begin
            in_event_reg <= in_event_next;
            skip_reg     <= skip_next;
            count_reg    <= count_next;
            pend_reg     <= pend_next;
            ovf_reg      <= ovf_next;
        end
    end

endmodule

>>> hdl/esf_result_buffer.sv
// ---------------------------------------------------------------------------
// esf_result_buffer
// Small result queue: takes up to two results a cycle, hands out one.
// ---------------------------------------------------------------------------
module esf_result_buffer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  esf_pkg::esf_push_t   push,
    input  logic                 pop,
    output logic                 room,
    output logic                 not_empty,
    output esf_pkg::esf_result_t head
);
    import esf_pkg::*;

    esf_result_t             entry_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [RES_PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [RES_PTR_W:0]      fill_reg, fill_next;
    logic [RES_PTR_W-1:0]    wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + RES_PTR_W'(1);

    // Room for the worst case of two results from the next word.
    assign room      = fill_reg <= (RES_PTR_W + 1)'(RES_DEPTH - 2);
    assign not_empty = fill_reg != '0;
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + RES_PTR_W'(push.count);
        rd_ptr_next = rd_ptr_reg + RES_PTR_W'(pop);
        fill_next   = fill_reg + (RES_PTR_W + 1)'(push.count)
                      - (RES_PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            entry_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            entry_reg[wr_ptr_plus1] <= push.second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> hdl/esf_checker.sv
// ---------------------------------------------------------------------------
// esf_assert_checker
// Port-level checks for the event stream framer core, bound to the top level.
// ---------------------------------------------------------------------------
`include "event_stream_framer_core_defines.svh"

module esf_assert_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [15:0] event_word,
    input logic        word_present,
    input logic        last,
    input logic        start_error,
    input logic        end_error,
    input logic        overflow,
    input logic        cfg_ready
);

    logic [20:0] out_word;

    assign out_word = {event_word, word_present, last, start_error, end_error, overflow};

    // A word waiting at the output must hold until it is taken.
    `ESF_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_word))

    // A close-only marker always ends its event and carries a zero word.
    `ESF_ASSERT_SAME(a_marker_form, clk, rst_n, out_valid && !word_present, last && (event_word == 16'd0))

    // An end error is reported only on a close-only marker.
    `ESF_ASSERT_SAME(a_end_err_marker, clk, rst_n, out_valid && end_error, !word_present && last)

    // The configuration port never stalls.
    `ESF_ASSERT_SAME(a_cfg_ready, clk, rst_n, 1'b1, cfg_ready)

endmodule

bind event_stream_framer_core esf_assert_checker u_esf_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .event_word   (event_word),
    .word_present (word_present),
    .last         (last),
    .start_error  (start_error),
    .end_error    (end_error),
    .overflow     (overflow),
    .cfg_ready    (cfg_ready)
);
